[src/kmp_pkg.sv]
// package with command codes, controller states and control/status bundles for the kmp matcher
`default_nettype none

package kmp_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_TEXT    = 2'd2,
        CMD_RESTART = 2'd3
    } kmp_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD_READ,
        ST_BUILD_CMP,
        ST_TEXT_READ,
        ST_TEXT_CMP,
        ST_TAB_READ,
        ST_TAB_SET,
        ST_EMIT
    } kmp_state_t;

    typedef struct packed {
        logic acc_clear;
        logic acc_restart;
        logic acc_append_first;
        logic acc_append_start;
        logic acc_text_start;
        logic step_fall;
        logic step_build_done;
        logic step_text_miss;
        logic step_text_hit;
        logic tab_read;
        logic tab_set;
        logic out_load;
    } kmp_ctrl_t;

    typedef struct packed {
        logic plen_zero;
        logic plen_full;
        logic len_zero;
        logic byte_eq;
        logic ext_full;
        logic out_free;
    } kmp_status_t;

endpackage

`default_nettype wire

[src/kmp_datapath.sv]
// kmp datapath: pattern and prefix memories, length and position registers, result output stage
`default_nettype none

module kmp_datapath #(
    parameter int MAX_PATTERN = 64,
    parameter int LEN_W       = 7,
    parameter int IDX_W       = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kmp_pkg::kmp_ctrl_t ctrl,
    output kmp_pkg::kmp_status_t    status,
    input  wire logic [7:0]         in_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_found,
    output logic [31:0]             out_start
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [7:0]       p_mem [MAX_PATTERN];
    logic [IDX_W-1:0] t_mem [MAX_PATTERN];

    logic [LEN_W-1:0] plen_reg,  plen_next;
    logic [IDX_W-1:0] bpl_reg,   bpl_next;
    logic [IDX_W-1:0] prog_reg,  prog_next;
    logic [31:0]      count_reg, count_next;
    logic [LEN_W-1:0] len_reg,   len_next;
    logic [7:0]       byte_reg;
    logic [7:0]       p_rd_reg;
    logic [IDX_W-1:0] t_rd_reg;
    logic             res_found_reg;
    logic [31:0]      res_start_reg;
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [31:0]      out_start_reg;

    logic [LEN_W-1:0] new_len;
    logic [IDX_W-1:0] t_raddr;
    logic             p_we;
    logic             t_we;
    logic [IDX_W-1:0] t_wdata;

    assign new_len = (p_rd_reg == byte_reg) ? len_reg + LEN_W'(1) : '0;
    assign t_raddr = ctrl.tab_read ? IDX_W'(plen_reg - LEN_W'(1)) : IDX_W'(len_reg - LEN_W'(1));
    assign p_we    = ctrl.acc_append_first | ctrl.acc_append_start;
    assign t_we    = ctrl.acc_append_first | ctrl.step_build_done;
    assign t_wdata = ctrl.acc_append_first ? '0 : new_len[IDX_W-1:0];

    assign status.plen_zero = (plen_reg == '0);
    assign status.plen_full = (plen_reg == MAX_LEN);
    assign status.len_zero  = (len_reg == '0);
    assign status.byte_eq   = (p_rd_reg == byte_reg);
    assign status.ext_full  = (new_len == plen_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_start = out_start_reg;

    // pattern and prefix memories
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            p_mem[plen_reg[IDX_W-1:0]] <= in_byte;
        end
        if (t_we)
        begin
            t_mem[plen_reg[IDX_W-1:0]] <= t_wdata;
        end
        p_rd_reg <= p_mem[len_reg[IDX_W-1:0]];
        t_rd_reg <= t_mem[t_raddr];
    end

    always_comb
    begin
        plen_next  = plen_reg;
        bpl_next   = bpl_reg;
        prog_next  = prog_reg;
        count_next = count_reg;
        len_next   = len_reg;
        if (ctrl.acc_clear)
        begin
            plen_next  = '0;
            bpl_next   = '0;
            prog_next  = '0;
            count_next = '0;
        end
        if (ctrl.acc_restart)
        begin
            prog_next  = '0;
            count_next = '0;
        end
        if (ctrl.acc_append_first)
        begin
            bpl_next  = '0;
            plen_next = LEN_W'(1);
        end
        if (ctrl.acc_append_start)
        begin
            len_next = LEN_W'(bpl_reg);
        end
        if (ctrl.acc_text_start)
        begin
            count_next = count_reg + 32'd1;
            len_next   = (LEN_W'(prog_reg) >= plen_reg) ? '0 : LEN_W'(prog_reg);
        end
        if (ctrl.step_fall)
        begin
            len_next = LEN_W'(t_rd_reg);
        end
        if (ctrl.step_build_done)
        begin
            bpl_next  = new_len[IDX_W-1:0];
            plen_next = plen_reg + LEN_W'(1);
        end
        if (ctrl.step_text_miss)
        begin
            prog_next = new_len[IDX_W-1:0];
        end
        if (ctrl.tab_set)
        begin
            prog_next = t_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            bpl_reg       <= '0;
            prog_reg      <= '0;
            count_reg     <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg  <= plen_next;
            bpl_reg   <= bpl_next;
            prog_reg  <= prog_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_append_start || ctrl.acc_text_start)
        begin
            byte_reg <= in_byte;
        end
        if (ctrl.step_text_miss)
        begin
            res_found_reg <= 1'b0;
            res_start_reg <= '0;
        end
        if (ctrl.step_text_hit)
        begin
            res_found_reg <= 1'b1;
            res_start_reg <= count_reg - 32'(plen_reg) + 32'd1;
        end
        if (ctrl.out_load)
        begin
            out_found_reg <= res_found_reg;
            out_start_reg <= res_start_reg;
        end
    end

endmodule

`default_nettype wire

[src/kmp_controller.sv]
// kmp controller: sequences pattern build, text scan with fallback, and result hand-off
`default_nettype none

module kmp_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           in_cmd,
    input  wire kmp_pkg::kmp_status_t status,
    output kmp_pkg::kmp_ctrl_t        ctrl
);

    kmp_pkg::kmp_state_t state_reg, state_next;
    kmp_pkg::kmp_cmd_t   cmd;
    logic                fall;

    assign cmd  = kmp_pkg::kmp_cmd_t'(in_cmd);
    assign fall = !status.len_zero && !status.byte_eq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == kmp_pkg::CMD_APPEND && !status.plen_full && !status.plen_zero)
                    begin
                        state_next = kmp_pkg::ST_BUILD_READ;
                    end
                    else if (cmd == kmp_pkg::CMD_TEXT && !status.plen_zero)
                    begin
                        state_next = kmp_pkg::ST_TEXT_READ;
                    end
                end
            end
            kmp_pkg::ST_BUILD_READ:
            begin
                state_next = kmp_pkg::ST_BUILD_CMP;
            end
            kmp_pkg::ST_BUILD_CMP:
            begin
                state_next = fall ? kmp_pkg::ST_BUILD_READ : kmp_pkg::ST_IDLE;
            end
            kmp_pkg::ST_TEXT_READ:
            begin
                state_next = kmp_pkg::ST_TEXT_CMP;
            end
            kmp_pkg::ST_TEXT_CMP:
            begin
                if (fall)
                begin
                    state_next = kmp_pkg::ST_TEXT_READ;
                end
                else if (status.ext_full)
                begin
                    state_next = kmp_pkg::ST_TAB_READ;
                end
                else
                begin
                    state_next = kmp_pkg::ST_EMIT;
                end
            end
            kmp_pkg::ST_TAB_READ:
            begin
                state_next = kmp_pkg::ST_TAB_SET;
            end
            kmp_pkg::ST_TAB_SET:
            begin
                state_next = kmp_pkg::ST_EMIT;
            end
            kmp_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = kmp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kmp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            kmp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (cmd)
                        kmp_pkg::CMD_CLEAR:
                        begin
                            ctrl.acc_clear = 1'b1;
                        end
                        kmp_pkg::CMD_RESTART:
                        begin
                            ctrl.acc_restart = 1'b1;
                        end
                        kmp_pkg::CMD_APPEND:
                        begin
                            if (!status.plen_full)
                            begin
                                ctrl.acc_append_first = status.plen_zero;
                                ctrl.acc_append_start = !status.plen_zero;
                            end
                        end
                        kmp_pkg::CMD_TEXT:
                        begin
                            ctrl.acc_text_start = !status.plen_zero;
                        end
                        default:
                        begin
                            ctrl = '0;
                        end
                    endcase
                end
            end
            kmp_pkg::ST_BUILD_CMP:
            begin
                ctrl.step_fall       = fall;
                ctrl.step_build_done = !fall;
            end
            kmp_pkg::ST_TEXT_CMP:
            begin
                ctrl.step_fall      = fall;
                ctrl.step_text_hit  = !fall && status.ext_full;
                ctrl.step_text_miss = !fall && !status.ext_full;
            end
            kmp_pkg::ST_TAB_READ:
            begin
                ctrl.tab_read = 1'b1;
            end
            kmp_pkg::ST_TAB_SET:
            begin
                ctrl.tab_set = 1'b1;
            end
            kmp_pkg::ST_EMIT:
            begin
                ctrl.out_load = status.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/kmp_stream_matcher_top.sv]
// top level of the streaming kmp matcher
// a text transaction reads and compares the pattern byte, again after each fallback, and on a match
// also reads the prefix table for the overlap restart; the result is loaded once the output is free
// an append completes on acceptance for the first byte, else reads and compares, again per fallback
// input is taken again once the current transaction is finished; each fallback costs
// one registered read of the pattern and prefix memories
// rst_n is asynchronous: pattern length, match state and position go to zero,
// memory contents are kept
`default_nettype none

module kmp_stream_matcher_top #(
    parameter int MAX_PATTERN = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // match_start[31:0]
    output logic [0:0]       m_tuser    // match_found[0]
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    kmp_pkg::kmp_ctrl_t   ctrl;
    kmp_pkg::kmp_status_t status;
    logic                 found;

    kmp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser),
        .status   (status),
        .ctrl     (ctrl)
    );

    kmp_datapath #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W),
        .IDX_W       (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_found (found),
        .out_start (m_tdata)
    );

    assign m_tuser[0] = found;

endmodule

`default_nettype wire

[src/kmp_checker.sv]
// port-level checker for the kmp matcher and its bind to the top level
`default_nettype none

module kmp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no start position without a match
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
        else $error("nonzero start without match");

    // results never appear in the cycle right after an input transaction
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !$rose(m_tvalid))
        else $error("result too soon after input");

    // clear and restart complete at once
    a_ctl_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_tuser == kmp_pkg::CMD_CLEAR || s_tuser == kmp_pkg::CMD_RESTART)
        |=> s_tready)
        else $error("not ready after clear or restart");

endmodule

bind kmp_stream_matcher_top kmp_checker u_kmp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
